// ===== hdl/lifet_pkg.sv =====
// ----------------------------------------------------------------------------
// lifet_pkg
// shared types and constants for the toroidal life automaton
// ----------------------------------------------------------------------------
`default_nettype none

package lifet_pkg;

    localparam int OP_W    = 2;
    localparam int COORD_W = 9;
    localparam int CFG_W   = 10;

    localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
    localparam logic [OP_W-1:0] OP_READ    = 2'd1;
    localparam logic [OP_W-1:0] OP_ADVANCE = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd3;

    localparam logic CFG_IDX_COLUMNS = 1'b0;
    localparam logic CFG_IDX_ROWS    = 1'b1;

    localparam logic [CFG_W-1:0] COLUMNS_RST = 10'd500;
    localparam logic [CFG_W-1:0] ROWS_RST    = 10'd300;

    // controller to datapath
    typedef struct packed {
        logic item_load;
        logic rd_item;
        logic rd_up;
        logic rd_cur;
        logic wr_clear;
        logic wr_item;
        logic take_bit;
        logic load_up;
        logic load_cur;
        logic load_dn;
        logic row_begin;
        logic cell_step;
        logic wr_next;
        logic result_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            in_range;
        logic            grid_empty;
        logic            clr_last;
        logic            col_last;
        logic            row_last;
    } t_sts;

endpackage

`default_nettype wire

// ===== hdl/life_automaton_torus_step.sv =====
// ----------------------------------------------------------------------------
// life_automaton_torus_step
// B3/S23 life automaton on a configurable torus with cell access and clear
// ----------------------------------------------------------------------------
// The grid is held as one row of MAX_COLUMNS cells per memory word, with one read
// port and one write port. After reset the block sweeps all MAX_ROWS rows to zero,
// one row a cycle, with s_axis_tready low. A cell write or an in-range read
// reads the addressed row, then writes it back or takes the bit; an out-of-range
// access goes straight to the result, and a clear sweeps all MAX_ROWS rows. An
// advance fetches the wrapped top row and the first row, then for each used row
// fetches the row below, updates one cell per cycle and writes the row back. A new
// item is accepted while the previous result still waits on the output.
`default_nettype none

module life_automaton_torus_step
    import lifet_pkg::*;
#(
    parameter int MAX_COLUMNS = 512,
    parameter int MAX_ROWS    = 512
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_wr_en,
    input  wire logic             i_cfg_index,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [23:0]      s_axis_tdata,  // column, row, write_value, zero pad
    input  wire logic [1:0]       s_axis_tuser,  // op
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic [7:0]            m_axis_tdata,  // read_value, zero pad
    output logic [1:0]            m_axis_tuser   // done_op
);

    t_cmd            cmd;
    t_sts            sts;
    logic [OP_W-1:0] done_op;
    logic            read_value;

    lifet_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    lifet_datapath #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_op          (s_axis_tuser),
        .i_column      (s_axis_tdata[8:0]),
        .i_row         (s_axis_tdata[17:9]),
        .i_write_value (s_axis_tdata[18]),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_done_op     (done_op),
        .o_read_value  (read_value)
    );

    assign m_axis_tuser = done_op;
    assign m_axis_tdata = {7'd0, read_value};

endmodule

`default_nettype wire

// ===== hdl/lifet_datapath.sv =====
// ----------------------------------------------------------------------------
// lifet_datapath
// row-wide grid memory, three-row window, cell update and item registers
// ----------------------------------------------------------------------------
`default_nettype none

module lifet_datapath
    import lifet_pkg::*;
#(
    parameter int MAX_COLUMNS = 512,
    parameter int MAX_ROWS    = 512
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr_en,
    input  wire logic               i_cfg_index,
    input  wire logic [CFG_W-1:0]   i_cfg_data,
    input  wire logic [OP_W-1:0]    i_op,
    input  wire logic [COORD_W-1:0] i_column,
    input  wire logic [COORD_W-1:0] i_row,
    input  wire logic               i_write_value,
    input  wire t_cmd               i_cmd,
    output t_sts                    o_sts,
    output logic [OP_W-1:0]         o_done_op,
    output logic                    o_read_value
);

    localparam int CW  = $clog2(MAX_COLUMNS);
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int UCW = $clog2(MAX_COLUMNS + 1);
    localparam int URW = $clog2(MAX_ROWS + 1);

    logic [CFG_W-1:0]       r_cfg_cols;
    logic [CFG_W-1:0]       r_cfg_rows;
    logic [OP_W-1:0]        r_item_op;
    logic [COORD_W-1:0]     r_item_col;
    logic [COORD_W-1:0]     r_item_row;
    logic                   r_item_wv;
    logic                   r_rv;
    logic [OP_W-1:0]        r_out_op;
    logic                   r_out_rv;
    logic [RW-1:0]          r_row;
    logic [CW-1:0]          r_col;
    logic [MAX_COLUMNS-1:0] r_mem [MAX_ROWS];
    logic [MAX_COLUMNS-1:0] r_rd_data;
    logic [MAX_COLUMNS-1:0] r_up;
    logic [MAX_COLUMNS-1:0] r_cur;
    logic [MAX_COLUMNS-1:0] r_dn;
    logic [MAX_COLUMNS-1:0] r_row0;
    logic [MAX_COLUMNS-1:0] r_next;

    logic [UCW-1:0]         used_cols;
    logic [URW-1:0]         used_rows;
    logic [RW-1:0]          item_row;
    logic [CW-1:0]          item_col;
    logic [RW-1:0]          dn_idx;
    logic [CW-1:0]          lf;
    logic [CW-1:0]          rt;
    logic [3:0]             nbr;
    logic                   new_bit;
    logic [MAX_COLUMNS-1:0] modified;
    logic                   mem_we;
    logic [RW-1:0]          mem_wa;
    logic [RW-1:0]          mem_ra;
    logic [MAX_COLUMNS-1:0] mem_wd;

    // size in use, saturated at the maximum
    always_comb begin
        if (32'(r_cfg_cols) > 32'(MAX_COLUMNS)) begin
            used_cols = UCW'(MAX_COLUMNS);
        end else begin
            used_cols = UCW'(r_cfg_cols);
        end
        if (32'(r_cfg_rows) > 32'(MAX_ROWS)) begin
            used_rows = URW'(MAX_ROWS);
        end else begin
            used_rows = URW'(r_cfg_rows);
        end
    end

    assign item_row = RW'(r_item_row);
    assign item_col = CW'(r_item_col);

    // torus neighbors
    always_comb begin
        if (URW'(r_row) + URW'(1) >= used_rows) begin
            dn_idx = '0;
        end else begin
            dn_idx = r_row + RW'(1);
        end
        if (r_col == '0) begin
            lf = CW'(used_cols - UCW'(1));
        end else begin
            lf = r_col - CW'(1);
        end
        if (UCW'(r_col) + UCW'(1) >= used_cols) begin
            rt = '0;
        end else begin
            rt = r_col + CW'(1);
        end
    end

    assign nbr = 4'(r_up[lf]) + 4'(r_cur[lf]) + 4'(r_dn[lf])
               + 4'(r_up[r_col]) + 4'(r_dn[r_col])
               + 4'(r_up[rt]) + 4'(r_cur[rt]) + 4'(r_dn[rt]);
    assign new_bit = (nbr == 4'd3) || ((nbr == 4'd2) && r_cur[r_col]);

    always_comb begin
        modified           = r_rd_data;
        modified[item_col] = r_item_wv;
    end

    // memory port selection
    always_comb begin
        if (i_cmd.rd_item) begin
            mem_ra = item_row;
        end else if (i_cmd.rd_up) begin
            mem_ra = RW'(used_rows - URW'(1));
        end else if (i_cmd.rd_cur) begin
            mem_ra = r_row;
        end else begin
            mem_ra = dn_idx;
        end
        mem_we = i_cmd.wr_clear | i_cmd.wr_item | i_cmd.wr_next;
        mem_wa = i_cmd.wr_item ? item_row : r_row;
        if (i_cmd.wr_clear) begin
            mem_wd = '0;
        end else if (i_cmd.wr_item) begin
            mem_wd = modified;
        end else begin
            mem_wd = r_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[mem_ra];
    end

    // configuration and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cols <= COLUMNS_RST;
            r_cfg_rows <= ROWS_RST;
            r_row      <= '0;
            r_col      <= '0;
        end else begin
            if (i_cfg_wr_en && (i_cfg_index == CFG_IDX_COLUMNS)) begin
                r_cfg_cols <= i_cfg_data;
            end
            if (i_cfg_wr_en && (i_cfg_index == CFG_IDX_ROWS)) begin
                r_cfg_rows <= i_cfg_data;
            end
            if (i_cmd.item_load) begin
                r_row <= '0;
            end else if (i_cmd.wr_clear || i_cmd.wr_next) begin
                r_row <= r_row + RW'(1);
            end
            if (i_cmd.row_begin) begin
                r_col <= '0;
            end else if (i_cmd.cell_step) begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.item_load) begin
            r_item_op  <= i_op;
            r_item_col <= i_column;
            r_item_row <= i_row;
            r_item_wv  <= i_write_value;
            r_rv       <= 1'b0;
        end else if (i_cmd.take_bit) begin
            r_rv <= r_rd_data[item_col];
        end
        if (i_cmd.result_load) begin
            r_out_op <= r_item_op;
            r_out_rv <= r_rv;
        end
        if (i_cmd.load_up) begin
            r_up <= r_rd_data;
        end else if (i_cmd.wr_next) begin
            r_up <= r_cur;
        end
        if (i_cmd.load_cur) begin
            r_cur  <= r_rd_data;
            r_row0 <= r_rd_data;
        end else if (i_cmd.wr_next) begin
            r_cur <= r_dn;
        end
        if (i_cmd.load_dn) begin
            r_dn <= (dn_idx == '0) ? r_row0 : r_rd_data;
        end
        if (i_cmd.row_begin) begin
            r_next <= r_cur;
        end else if (i_cmd.cell_step) begin
            r_next[r_col] <= new_bit;
        end
    end

    always_comb begin
        o_sts.op         = r_item_op;
        o_sts.in_range   = (32'(r_item_col) < 32'(used_cols))
                        && (32'(r_item_row) < 32'(used_rows));
        o_sts.grid_empty = (used_cols == '0) || (used_rows == '0);
        o_sts.clr_last   = (r_row == RW'(MAX_ROWS - 1));
        o_sts.col_last   = (UCW'(r_col) == used_cols - UCW'(1));
        o_sts.row_last   = (URW'(r_row) == used_rows - URW'(1));
    end

    assign o_done_op    = r_out_op;
    assign o_read_value = r_out_rv;

endmodule

`default_nettype wire

// ===== hdl/lifet_ctrl.sv =====
// ----------------------------------------------------------------------------
// lifet_ctrl
// sequencer for cell access, clear sweep and generation advance
// ----------------------------------------------------------------------------
`default_nettype none

module lifet_ctrl
    import lifet_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    localparam logic [3:0] S_INIT     = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_DISP     = 4'd2;
    localparam logic [3:0] S_ACC_RD   = 4'd3;
    localparam logic [3:0] S_ACC_DO   = 4'd4;
    localparam logic [3:0] S_CLR      = 4'd5;
    localparam logic [3:0] S_ADV_UP   = 4'd6;
    localparam logic [3:0] S_ADV_CUR  = 4'd7;
    localparam logic [3:0] S_ADV_DN0  = 4'd8;
    localparam logic [3:0] S_ADV_DN   = 4'd9;
    localparam logic [3:0] S_ADV_LDN  = 4'd10;
    localparam logic [3:0] S_ADV_CELL = 4'd11;
    localparam logic [3:0] S_ADV_WR   = 4'd12;
    localparam logic [3:0] S_DONE     = 4'd13;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_INIT: begin
                o_cmd.wr_clear = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.item_load = 1'b1;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                if (i_sts.op inside {OP_WRITE, OP_READ}) begin
                    n_state = i_sts.in_range ? S_ACC_RD : S_DONE;
                end else if (i_sts.op == OP_ADVANCE) begin
                    n_state = i_sts.grid_empty ? S_DONE : S_ADV_UP;
                end else begin
                    n_state = S_CLR;
                end
            end
            S_ACC_RD: begin
                o_cmd.rd_item = 1'b1;
                n_state = S_ACC_DO;
            end
            S_ACC_DO: begin
                if (i_sts.op == OP_WRITE) begin
                    o_cmd.wr_item = 1'b1;
                end else begin
                    o_cmd.take_bit = 1'b1;
                end
                n_state = S_DONE;
            end
            S_CLR: begin
                o_cmd.wr_clear = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_DONE;
                end
            end
            S_ADV_UP: begin
                o_cmd.rd_up = 1'b1;
                n_state = S_ADV_CUR;
            end
            S_ADV_CUR: begin
                o_cmd.load_up = 1'b1;
                o_cmd.rd_cur  = 1'b1;
                n_state = S_ADV_DN0;
            end
            S_ADV_DN0: begin
                o_cmd.load_cur = 1'b1;
                n_state = S_ADV_LDN;
            end
            S_ADV_DN: begin
                n_state = S_ADV_LDN;
            end
            S_ADV_LDN: begin
                o_cmd.load_dn   = 1'b1;
                o_cmd.row_begin = 1'b1;
                n_state = S_ADV_CELL;
            end
            S_ADV_CELL: begin
                o_cmd.cell_step = 1'b1;
                if (i_sts.col_last) begin
                    n_state = S_ADV_WR;
                end
            end
            S_ADV_WR: begin
                o_cmd.wr_next = 1'b1;
                n_state = i_sts.row_last ? S_DONE : S_ADV_DN;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.result_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.result_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== tb/tb_life_automaton_torus_step.sv =====
// ----------------------------------------------------------------------------
// tb_life_automaton_torus_step
// checks cell access, clear and generation steps of the toroidal life block
// ----------------------------------------------------------------------------
// Each accepted item is applied to a shadow copy of the grid and of the size
// registers, which yields the expected op echo and read value. Results are
// compared in order as they leave the block. Directed items cover the default
// size, the saturated full grid with wraparound, grids of zero and one cell per
// side and one of 2 columns by 3 rows. Random phases follow, each on a new small
// grid size, with random idling on both streams and one long phase without it.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_life_automaton_torus_step;
    import lifet_pkg::*;

    localparam int GRID_COLS    = 512;
    localparam int GRID_ROWS    = 512;
    localparam int RANDOM_ITEMS = 2000;

    typedef struct {
        logic [OP_W-1:0] op;
        logic            read_value;
    } t_cell_result;

    class t_torus_tracker;
        logic [CFG_W-1:0]     columns_reg;
        logic [CFG_W-1:0]     rows_reg;
        bit [GRID_COLS-1:0]   live_cells [GRID_ROWS];
        bit [GRID_COLS-1:0]   next_cells [GRID_ROWS];
        t_cell_result         due_results [$];
        int                   mismatch_count;

        function new();
            columns_reg = COLUMNS_RST;
            rows_reg    = ROWS_RST;
            foreach (live_cells[r]) begin
                live_cells[r] = '0;
            end
            mismatch_count = 0;
        endfunction

        function int used_columns();
            return (columns_reg > GRID_COLS) ? GRID_COLS : int'(columns_reg);
        endfunction

        function int used_rows();
            return (rows_reg > GRID_ROWS) ? GRID_ROWS : int'(rows_reg);
        endfunction

        function void set_size(logic idx, logic [CFG_W-1:0] value);
            if (idx == CFG_IDX_COLUMNS) begin
                columns_reg = value;
            end else begin
                rows_reg = value;
            end
        endfunction

        function void step_generation();
            int cols, rows, up, dn, lf, rt, n;
            cols = used_columns();
            rows = used_rows();
            for (int r = 0; r < rows; r++) begin
                up = (r == 0) ? rows - 1 : r - 1;
                dn = (r + 1 >= rows) ? 0 : r + 1;
                for (int c = 0; c < cols; c++) begin
                    lf = (c == 0) ? cols - 1 : c - 1;
                    rt = (c + 1 >= cols) ? 0 : c + 1;
                    n = int'(live_cells[up][lf]) + int'(live_cells[r][lf])
                      + int'(live_cells[dn][lf]) + int'(live_cells[up][c])
                      + int'(live_cells[dn][c]) + int'(live_cells[up][rt])
                      + int'(live_cells[r][rt]) + int'(live_cells[dn][rt]);
                    next_cells[r][c] = (n == 3) || ((n == 2) && live_cells[r][c]);
                end
            end
            for (int r = 0; r < rows; r++) begin
                for (int c = 0; c < cols; c++) begin
                    live_cells[r][c] = next_cells[r][c];
                end
            end
        endfunction

        function void apply_item(logic [OP_W-1:0] op, logic [COORD_W-1:0] col,
                                 logic [COORD_W-1:0] row, logic wv);
            bit           in_range;
            t_cell_result res;
            in_range = (col < used_columns()) && (row < used_rows());
            res.op = op;
            res.read_value = 1'b0;
            case (op)
                OP_WRITE: begin
                    if (in_range) live_cells[row][col] = wv;
                end
                OP_READ: begin
                    if (in_range) res.read_value = live_cells[row][col];
                end
                OP_ADVANCE: begin
                    step_generation();
                end
                OP_CLEAR: begin
                    foreach (live_cells[r]) live_cells[r] = '0;
                end
                default: begin
                end
            endcase
            due_results = {due_results, res};
        endfunction

        task report_mismatch(string what);
            $display("%0t ns: mismatch: %s", $time, what);
            mismatch_count++;
        endtask

        task check_result(logic [OP_W-1:0] op, logic read_value);
            t_cell_result want;
            if (due_results.size() == 0) begin
                report_mismatch($sformatf("result op %0d with no item pending", op));
                return;
            end
            want = due_results.pop_front();
            if (op !== want.op) begin
                report_mismatch($sformatf("done_op %0d, expected %0d", op, want.op));
            end
            if (read_value !== want.read_value) begin
                report_mismatch($sformatf("read_value %0b, expected %0b (op %0d)",
                                          read_value, want.read_value, want.op));
            end
        endtask
    endclass

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             i_cfg_wr_en   = 1'b0;
    logic             i_cfg_index   = CFG_IDX_COLUMNS;
    logic [CFG_W-1:0] i_cfg_data    = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [23:0]      s_axis_tdata  = '0;  // column, row, write_value, zero pad
    logic [1:0]       s_axis_tuser  = '0;  // op
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [7:0]       m_axis_tdata;        // read_value, zero pad
    logic [1:0]       m_axis_tuser;        // done_op

    t_torus_tracker board;
    bit             stalls_on = 1'b1;
    int             random_sent = 0;

    life_automaton_torus_step #(
        .MAX_COLUMNS(GRID_COLS),
        .MAX_ROWS   (GRID_ROWS)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            board.check_result(m_axis_tuser, m_axis_tdata[0]);
        end
        m_axis_tready <= !stalls_on || ($urandom_range(0, 99) >= 36);
    end

    task automatic send_item(input logic [OP_W-1:0] op, input logic [COORD_W-1:0] col,
                             input logic [COORD_W-1:0] row, input logic wv);
        while (stalls_on && $urandom_range(0, 99) < 36) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {5'd0, wv, row, col};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.apply_item(op, col, row, wv);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (board.due_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic resize(input logic [CFG_W-1:0] cols, input logic [CFG_W-1:0] rows);
        wait_drained();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_IDX_COLUMNS;
        i_cfg_data  <= cols;
        @(posedge i_clk);
        i_cfg_index <= CFG_IDX_ROWS;
        i_cfg_data  <= rows;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        board.set_size(CFG_IDX_COLUMNS, cols);
        board.set_size(CFG_IDX_ROWS, rows);
    endtask

    function automatic logic [CFG_W-1:0] pick_size();
        int k;
        k = $urandom_range(0, 99);
        if (k < 4) return '0;
        if (k < 12) return CFG_W'($urandom_range(1, 2));
        if (k < 75) return CFG_W'($urandom_range(3, 8));
        return CFG_W'($urandom_range(9, 24));
    endfunction

    task automatic send_random_item();
        int              pick, cols, rows;
        logic [OP_W-1:0] op;
        logic [COORD_W-1:0] col, row;
        logic            wv;
        cols = board.used_columns();
        rows = board.used_rows();
        pick = $urandom_range(0, 99);
        if (pick < 42) begin
            op = OP_WRITE;
        end else if (pick < 82) begin
            op = OP_READ;
        end else if (pick < 97) begin
            op = OP_ADVANCE;
        end else begin
            op = OP_CLEAR;
        end
        if (cols == 0 || rows == 0 || $urandom_range(0, 9) == 0) begin
            col = COORD_W'($urandom_range(0, (1 << COORD_W) - 1));
            row = COORD_W'($urandom_range(0, (1 << COORD_W) - 1));
        end else begin
            col = COORD_W'($urandom_range(0, cols - 1));
            row = COORD_W'($urandom_range(0, rows - 1));
        end
        wv = ($urandom_range(0, 99) < 40);
        send_item(op, col, row, wv);
        random_sent++;
    endtask

    initial begin
        int phase, burst;
        board = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // default size, edges of the used area
        send_item(OP_READ,  9'd511, 9'd511, 1'b0);
        send_item(OP_WRITE, 9'd499, 9'd299, 1'b1);
        send_item(OP_READ,  9'd499, 9'd299, 1'b0);
        send_item(OP_WRITE, 9'd500, 9'd0,   1'b1);
        send_item(OP_WRITE, 9'd0,   9'd300, 1'b1);
        send_item(OP_READ,  9'd0,   9'd300, 1'b0);

        // oversized registers saturate to the full grid
        resize(10'h3FF, 10'h3FF);
        send_item(OP_READ,    9'd500, 9'd0,   1'b0);
        send_item(OP_WRITE,   9'd511, 9'd0,   1'b1);
        send_item(OP_WRITE,   9'd0,   9'd0,   1'b1);
        send_item(OP_WRITE,   9'd1,   9'd0,   1'b1);
        send_item(OP_ADVANCE, 9'h1FF, 9'h1FF, 1'b1);
        send_item(OP_READ,    9'd0,   9'd511, 1'b0);
        send_item(OP_READ,    9'd0,   9'd1,   1'b0);
        send_item(OP_READ,    9'd499, 9'd299, 1'b0);
        send_item(OP_CLEAR,   9'h1FF, 9'h1FF, 1'b1);
        send_item(OP_READ,    9'd500, 9'd0,   1'b0);

        // empty, single-cell and two-wide tori
        resize('0, '0);
        send_item(OP_WRITE,   9'd0, 9'd0, 1'b1);
        send_item(OP_READ,    9'd0, 9'd0, 1'b0);
        send_item(OP_ADVANCE, 9'd0, 9'd0, 1'b0);
        resize(10'd1, 10'd1);
        send_item(OP_WRITE,   9'd0, 9'd0, 1'b1);
        send_item(OP_ADVANCE, 9'd0, 9'd0, 1'b0);
        send_item(OP_READ,    9'd0, 9'd0, 1'b0);
        resize(10'd2, 10'd3);
        send_item(OP_WRITE,   9'd0, 9'd0, 1'b1);
        send_item(OP_WRITE,   9'd1, 9'd0, 1'b1);
        send_item(OP_ADVANCE, 9'd0, 9'd0, 1'b0);
        send_item(OP_READ,    9'd0, 9'd0, 1'b0);

        phase = 0;
        while (random_sent < RANDOM_ITEMS) begin
            resize(pick_size(), pick_size());
            stalls_on = (phase != 3);
            burst = (phase == 3) ? 300 : $urandom_range(40, 120);
            repeat (burst) send_random_item();
            // read back the whole torus when it is small
            if (board.used_columns() * board.used_rows() <= 64) begin
                for (int r = 0; r < board.used_rows(); r++) begin
                    for (int c = 0; c < board.used_columns(); c++) begin
                        send_item(OP_READ, COORD_W'(c), COORD_W'(r), 1'b0);
                    end
                end
            end
            phase++;
        end

        stalls_on = 1'b1;
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (board.mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== life_automaton_torus_step.f =====
hdl/lifet_pkg.sv
hdl/lifet_datapath.sv
hdl/lifet_ctrl.sv
hdl/life_automaton_torus_step.sv
tb/tb_life_automaton_torus_step.sv
